FILE: rtl/core/pwp_pkg.sv
// Shared types and constants for the prefetch window planner.
// No dependencies; pwp_ctrl, pwp_dp and the top level import this package.
package pwp_pkg;

  // APB register indexes (byte address / 4)
  localparam logic [2:0] REG_CACHE_SLOTS   = 3'd0;
  localparam logic [2:0] REG_FILL_FRACTION = 3'd1;
  localparam logic [2:0] REG_BALANCE_MODE  = 3'd2;
  localparam logic [2:0] REG_TIME_COUNT    = 3'd3;
  localparam logic [2:0] REG_SECTION_COUNT = 3'd4;

  localparam logic [10:0] SLOTS_MAX = 11'd1024;

  localparam logic [1:0] FILL_SHIFT [3] = '{2'd0, 2'd1, 2'd2};

  typedef enum logic [1:0] {
    MODE_ALL   = 2'd0,
    MODE_ADJ   = 2'd1,
    MODE_FAVOR = 2'd2,
    MODE_ONLY  = 2'd3
  } pwp_mode_e;

  typedef struct packed {
    logic [10:0] cache_slots;
    logic [1:0]  fill_fraction;
    pwp_mode_e   balance_mode;
    logic [6:0]  time_count;
    logic [12:0] section_count;
  } pwp_cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_CAPTURE,
    OP_BLANK_WR,
    OP_DIV_FILL_NT,
    OP_DIV_FILL_NADJ,
    OP_DIV_SPLIT,
    OP_DIV_LEFT,
    OP_SET_CS_QUOT,
    OP_SET_CS_FILL,
    OP_SET_BASE,
    OP_SHARE_CS,
    OP_SHARE_I,
    OP_SPLIT,
    OP_WALK_S,
    OP_WALK_E0,
    OP_WALK_E,
    OP_WALK_S2,
    OP_TAKE_S,
    OP_TAKE_E,
    OP_NLEFT,
    OP_I_INIT,
    OP_EMIT
  } pwp_op_e;

  typedef struct packed {
    logic      is_write;
    pwp_mode_e mode;
    logic      div_busy;
    logic      walk_busy;
    logic      wz_neg;
    logic      wz_hi;
    logic      left_need;
    logic      can_emit;
    logic      i_last;
    logic      clr_last;
  } pwp_stat_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_CS_DIV,
    ST_P1_SHARE,
    ST_LIM_DIV,
    ST_LIM_DIVW,
    ST_WS_GO,
    ST_WS_W,
    ST_WE0_GO,
    ST_WE0_W,
    ST_WE_GO,
    ST_WE_W,
    ST_WS2_GO,
    ST_WS2_W,
    ST_LIM_END,
    ST_LEFT_DIV,
    ST_BASE_DIV,
    ST_P2_INIT,
    ST_P2_SHARE,
    ST_EMIT
  } pwp_state_e;

  function automatic logic [1:0] fill_shift(input logic [1:0] f);
    fill_shift = (f > 2'd2) ? FILL_SHIFT[2] : FILL_SHIFT[f];
  endfunction

endpackage

FILE: rtl/core/prefetch_window_planner_top.sv
// Top level of the prefetch window planner: APB registers and stream ports.
// Depends on pwp_pkg, pwp_ctrl and pwp_dp.
//
// Plans per-time section windows for a slice cache. A write beat (tuser 0)
// sets one blank-map bit. A plan beat (tuser 1) returns one window beat per
// time point, in ascending order, tlast on the final one. Each window waits
// on the serial divider (DW = 19 at the default MAX_SECTIONS), passes through
// the sequencing states, and then runs its blank-map walks, in which the
// walker reads one bit per RAM access. A plan in the all mode, and in the
// adjacent and favor modes when the leftover divisor is nonzero, also makes
// one budget division; the adjacent and favor modes first place the central
// window. After reset the blank map is cleared before any beat is taken;
// configuration writes are accepted throughout.
module prefetch_window_planner_top
  import pwp_pkg::*;
#(
  parameter int MAX_SECTIONS = 4096,
  parameter int MAX_TIMES    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [11:0] section, [12] blank_bit, [19:13] current_time,
  // [22:20] weight_before, [25:23] weight_after
  input  logic [31:0] s_axis_tdata_i,
  // [0] opcode
  input  logic [0:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [6:0] time_index, [19:7] window_start, [32:20] window_end
  output logic [39:0] m_axis_tdata_o,
  // [0] window_empty
  output logic [0:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  pwp_cfg_t  cfg_q;
  pwp_op_e   op;
  pwp_stat_t stat;
  logic      cfg_we;
  logic [6:0] nt_chk;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cache_slots   <= 11'd16;
      cfg_q.fill_fraction <= 2'd0;
      cfg_q.balance_mode  <= MODE_ALL;
      cfg_q.time_count    <= 7'd1;
      cfg_q.section_count <= 13'd4096;
    end else if (cfg_we) begin
      unique case (paddr_i[4:2])
        REG_CACHE_SLOTS:   cfg_q.cache_slots   <= pwdata_i[10:0];
        REG_FILL_FRACTION: cfg_q.fill_fraction <= pwdata_i[1:0];
        REG_BALANCE_MODE:  cfg_q.balance_mode  <= pwp_mode_e'(pwdata_i[1:0]);
        REG_TIME_COUNT:    cfg_q.time_count    <= pwdata_i[6:0];
        REG_SECTION_COUNT: cfg_q.section_count <= pwdata_i[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[4:2])
      REG_CACHE_SLOTS:   prdata_o = 32'(cfg_q.cache_slots);
      REG_FILL_FRACTION: prdata_o = 32'(cfg_q.fill_fraction);
      REG_BALANCE_MODE:  prdata_o = 32'(cfg_q.balance_mode);
      REG_TIME_COUNT:    prdata_o = 32'(cfg_q.time_count);
      REG_SECTION_COUNT: prdata_o = 32'(cfg_q.section_count);
      default:           prdata_o = '0;
    endcase
  end

  pwp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .stat_i     (stat),
    .op_o       (op),
    .in_ready_o (s_axis_tready_o)
  );

  pwp_dp #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .MAX_TIMES    (MAX_TIMES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .op_i        (op),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i[0]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o[0]),
    .out_last_o  (m_axis_tlast_o),
    .stat_o      (stat)
  );

  always_comb begin
    nt_chk = cfg_q.time_count;
    if (nt_chk == 7'd0) nt_chk = 7'd1;
    if (32'(nt_chk) > MAX_TIMES) nt_chk = 7'(MAX_TIMES);
  end

  // windows come out in ascending time order
  a_time_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=>
      (!m_axis_tvalid_o ||
       (m_axis_tdata_o[6:0] == $past(m_axis_tdata_o[6:0]) + 7'd1)))
    else $error("window time index did not advance by one");

  a_time_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=>
      (!m_axis_tvalid_o || (m_axis_tdata_o[6:0] == 7'd1)))
    else $error("plan did not start at time one");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tdata_o[6:0] == nt_chk))
    else $error("tlast on a window other than the final time point");

endmodule

FILE: rtl/core/pwp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pwp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/pwp_div.sv
// Bit-serial signed divider, truncating toward zero, small unsigned divisor.
// No dependencies.
module pwp_div #(
  parameter int DW = 18
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] dividend_i,
  input  logic [6:0]           divisor_i,
  output logic                 busy_o,
  output logic signed [DW-1:0] quot_o,
  output logic signed [DW-1:0] rem_o
);

  localparam int CW = $clog2(DW) + 1;

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] q_q;
  logic [6:0]    r_q;
  logic [6:0]    d_q;
  logic          negq_q, negr_q;
  logic [7:0]    trial;
  logic          fits;
  logic [DW-1:0] mag;

  assign trial = {r_q, q_q[DW-1]};
  assign fits  = trial >= {1'b0, d_q};
  assign mag   = dividend_i[DW-1] ? DW'(-dividend_i) : DW'(dividend_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q    <= mag;
      r_q    <= '0;
      d_q    <= divisor_i;
      negq_q <= dividend_i[DW-1];
      negr_q <= dividend_i[DW-1];
    end else if (busy_q) begin
      q_q <= {q_q[DW-2:0], fits};
      r_q <= fits ? 7'(trial - {1'b0, d_q}) : trial[6:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = negq_q ? -$signed(q_q) : $signed(q_q);
  assign rem_o  = negr_q ? -$signed(DW'(r_q)) : $signed(DW'(r_q));

endmodule

FILE: rtl/core/pwp_ctrl.sv
// Sequencer for the planner: clearing pass, blank writes and the plan steps.
// Depends on pwp_pkg; drives pwp_dp through op codes and reads its status.
module pwp_ctrl
  import pwp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  pwp_stat_t stat_i,
  output pwp_op_e   op_o,
  output logic      in_ready_o
);

  pwp_state_e state_q, state_d;
  logic       pass2_q, pass2_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      pass2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pass2_q <= pass2_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pass2_d    = pass2_q;
    op_o       = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        op_o = OP_CLR;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o    = OP_CAPTURE;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        pass2_d = 1'b0;
        if (stat_i.is_write) begin
          op_o    = OP_BLANK_WR;
          state_d = ST_IDLE;
        end else begin
          unique case (stat_i.mode)
            MODE_ALL: begin
              op_o    = OP_DIV_FILL_NT;
              state_d = ST_BASE_DIV;
            end
            MODE_ADJ: begin
              op_o    = OP_DIV_FILL_NADJ;
              state_d = ST_CS_DIV;
            end
            MODE_FAVOR: begin
              op_o    = OP_SET_CS_FILL;
              state_d = ST_P1_SHARE;
            end
            MODE_ONLY: begin
              op_o    = OP_SET_CS_FILL;
              state_d = ST_P2_INIT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CS_DIV: begin
        if (!stat_i.div_busy) begin
          op_o    = OP_SET_CS_QUOT;
          state_d = ST_P1_SHARE;
        end
      end
      ST_P1_SHARE: begin
        op_o    = OP_SHARE_CS;
        state_d = ST_LIM_DIV;
      end
      ST_LIM_DIV: begin
        op_o    = OP_DIV_SPLIT;
        state_d = ST_LIM_DIVW;
      end
      ST_LIM_DIVW: begin
        if (!stat_i.div_busy) begin
          op_o    = OP_SPLIT;
          state_d = ST_WS_GO;
        end
      end
      ST_WS_GO: begin
        op_o    = OP_WALK_S;
        state_d = ST_WS_W;
      end
      ST_WS_W: begin
        if (!stat_i.walk_busy) begin
          op_o    = OP_TAKE_S;
          state_d = stat_i.wz_neg ? ST_WE0_GO : ST_WE_GO;
        end
      end
      ST_WE0_GO: begin
        op_o    = OP_WALK_E0;
        state_d = ST_WE0_W;
      end
      ST_WE0_W: begin
        if (!stat_i.walk_busy) begin
          op_o    = OP_TAKE_E;
          state_d = ST_LIM_END;
        end
      end
      ST_WE_GO: begin
        op_o    = OP_WALK_E;
        state_d = ST_WE_W;
      end
      ST_WE_W: begin
        if (!stat_i.walk_busy) begin
          op_o    = OP_TAKE_E;
          state_d = stat_i.wz_hi ? ST_WS2_GO : ST_LIM_END;
        end
      end
      ST_WS2_GO: begin
        op_o    = OP_WALK_S2;
        state_d = ST_WS2_W;
      end
      ST_WS2_W: begin
        if (!stat_i.walk_busy) begin
          op_o    = OP_TAKE_S;
          state_d = ST_LIM_END;
        end
      end
      ST_LIM_END: begin
        if (pass2_q) begin
          state_d = ST_EMIT;
        end else begin
          op_o    = OP_NLEFT;
          state_d = ST_LEFT_DIV;
        end
      end
      ST_LEFT_DIV: begin
        if (stat_i.left_need) begin
          op_o    = OP_DIV_LEFT;
          state_d = ST_BASE_DIV;
        end else begin
          state_d = ST_P2_INIT;
        end
      end
      ST_BASE_DIV: begin
        if (!stat_i.div_busy) begin
          op_o    = OP_SET_BASE;
          state_d = ST_P2_INIT;
        end
      end
      ST_P2_INIT: begin
        op_o    = OP_I_INIT;
        pass2_d = 1'b1;
        state_d = ST_P2_SHARE;
      end
      ST_P2_SHARE: begin
        op_o    = OP_SHARE_I;
        state_d = ST_LIM_DIV;
      end
      ST_EMIT: begin
        if (stat_i.can_emit) begin
          op_o    = OP_EMIT;
          state_d = stat_i.i_last ? ST_IDLE : ST_P2_SHARE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/pwp_dp.sv
// Planner datapath: item registers, budget split, blank-map walker, output beat.
// Depends on pwp_pkg, pwp_ram and pwp_div; sequenced by pwp_ctrl.
module pwp_dp
  import pwp_pkg::*;
#(
  parameter int MAX_SECTIONS = 4096,
  parameter int MAX_TIMES    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pwp_cfg_t    cfg_i,
  input  pwp_op_e     op_i,
  input  logic [31:0] in_data_i,
  input  logic        in_user_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [39:0] out_data_o,
  output logic        out_user_o,
  output logic        out_last_o,
  output pwp_stat_t   stat_o
);

  localparam int AW  = $clog2(MAX_SECTIONS);
  localparam int ZSW = AW + 1;
  localparam int ZW  = AW + 2;
  localparam int VW  = ((AW > 11) ? AW : 11) + 4;
  localparam int DW  = VW + 3;
  localparam logic signed [ZW-1:0] Z_ONE  = ZW'(1);
  localparam logic signed [ZW-1:0] Z_ZERO = ZW'(0);
  localparam logic signed [VW-1:0] V_ONE  = VW'(1);
  localparam logic signed [VW-1:0] V_ZERO = VW'(0);

  // configuration after saturation
  logic [10:0]            slots, nfill_u;
  logic [6:0]             nt;
  logic [ZSW-1:0]         zs;
  logic signed [ZW-1:0]   zs_s, zs_m1;
  logic signed [VW-1:0]   nfill;

  // captured item
  logic                   wr_q, blank_q;
  logic [11:0]            sec_q;
  logic [6:0]             ct_q;
  logic [2:0]             wb_q, wa_q;
  logic signed [ZW-1:0]   cz_q;
  logic [6:0]             ct_new;
  logic [2:0]             wb_new, wa_new;
  logic signed [ZW-1:0]   cz_new;

  // plan registers
  logic signed [VW-1:0]   cs_q, nleft_q, nbase_q, nextra_q, n_q, nb_q, na_q;
  logic signed [ZW-1:0]   s_q, e_q;
  logic [6:0]             i_q;
  logic [6:0]             ts, te, nadj, left_dvs;
  logic                   central;
  logic signed [VW-1:0]   share_i, ext, ext_sum, q_v;

  // divider
  logic                   div_start, div_busy;
  logic signed [DW-1:0]   div_dvd, quot, rem, prod;
  logic [6:0]             div_dvs;
  logic [2:0]             wsel;

  // walker
  logic                   wbusy_q, wph_q;
  logic signed [ZW-1:0]   wz_q, znext, worg;
  logic signed [VW-1:0]   wst_q, wst_n, wsteps;
  logic                   wstart, wpos, zout;
  logic                   rd_blank;

  // clearing pass and RAM write
  logic [AW-1:0]          clr_q;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;

  logic                   out_valid_q, out_user_q, out_last_q;
  logic [39:0]            out_data_q;
  logic signed [31:0]     s_ext, e_ext;

  always_comb begin
    slots = cfg_i.cache_slots;
    if (slots == 11'd0) slots = 11'd1;
    if (slots > SLOTS_MAX) slots = SLOTS_MAX;
    nfill_u = slots >> fill_shift(cfg_i.fill_fraction);
    if (nfill_u == 11'd0) nfill_u = 11'd1;
    nt = cfg_i.time_count;
    if (nt == 7'd0) nt = 7'd1;
    if (32'(nt) > MAX_TIMES) nt = 7'(MAX_TIMES);
    if (cfg_i.section_count == 13'd0) begin
      zs = ZSW'(1);
    end else if (32'(cfg_i.section_count) > MAX_SECTIONS) begin
      zs = ZSW'(MAX_SECTIONS);
    end else begin
      zs = ZSW'(cfg_i.section_count);
    end
  end

  assign nfill = $signed(VW'(nfill_u));
  assign zs_s  = $signed(ZW'(zs));
  assign zs_m1 = zs_s - Z_ONE;

  // saturate the plan fields as they are captured
  always_comb begin
    ct_new = in_data_i[19:13];
    if (ct_new == 7'd0) ct_new = 7'd1;
    if (ct_new > nt) ct_new = nt;
    wb_new = (in_data_i[22:20] == 3'd0) ? 3'd1 : in_data_i[22:20];
    wa_new = (in_data_i[25:23] == 3'd0) ? 3'd1 : in_data_i[25:23];
    if (32'(in_data_i[11:0]) >= 32'(zs)) begin
      cz_new = zs_m1;
    end else begin
      cz_new = $signed(ZW'(in_data_i[11:0]));
    end
  end

  // budget split
  always_comb begin
    ts       = (ct_q <= 7'd1) ? 7'd1 : ct_q - 7'd1;
    te       = (ct_q >= nt) ? nt : ct_q + 7'd1;
    nadj     = te + 7'd1 - ts;
    left_dvs = (cfg_i.balance_mode == MODE_ADJ) ? nt - nadj : nt - 7'd1;
    unique case (cfg_i.balance_mode)
      MODE_ADJ:             central = (i_q >= ts) && (i_q <= te);
      MODE_FAVOR, MODE_ONLY: central = (i_q == ct_q);
      default:              central = 1'b0;
    endcase
    if (central) begin
      share_i = cs_q;
    end else if (cfg_i.balance_mode == MODE_ONLY) begin
      share_i = '0;
    end else begin
      share_i = nbase_q + (($signed(VW'(i_q)) <= nextra_q) ? V_ONE : '0);
    end
    ext     = $signed(VW'(e_q)) - $signed(VW'(s_q)) + V_ONE;
    ext_sum = ext;
    if (cfg_i.balance_mode == MODE_ADJ) begin
      if (nadj >= 7'd2) ext_sum = ext_sum + ext;
      if (nadj == 7'd3) ext_sum = ext_sum + ext;
    end
  end

  // divider operand selection
  assign wsel = (wb_q > wa_q) ? wb_q : wa_q;
  assign prod = DW'(n_q) * $signed(DW'({1'b0, wsel}));
  assign q_v  = VW'(quot);

  always_comb begin
    div_start = 1'b1;
    div_dvd   = DW'(nfill);
    div_dvs   = nt;
    unique case (op_i)
      OP_DIV_FILL_NT:   div_dvs = nt;
      OP_DIV_FILL_NADJ: div_dvs = nadj;
      OP_DIV_SPLIT: begin
        div_dvd = prod;
        div_dvs = 7'({1'b0, wb_q} + {1'b0, wa_q});
      end
      OP_DIV_LEFT: begin
        div_dvd = DW'(nleft_q);
        div_dvs = left_dvs;
      end
      default: div_start = 1'b0;
    endcase
  end

  pwp_div #(.DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // walker: each section visited takes an address step, then a step on the registered RAM data
  always_comb begin
    wstart = 1'b1;
    worg   = cz_q;
    wsteps = -nb_q;
    unique case (op_i)
      OP_WALK_S: begin
        worg   = cz_q;
        wsteps = -nb_q;
      end
      OP_WALK_E0: begin
        worg   = '0;
        wsteps = n_q - V_ONE;
      end
      OP_WALK_E: begin
        worg   = cz_q;
        wsteps = na_q;
      end
      OP_WALK_S2: begin
        worg   = zs_m1;
        wsteps = V_ONE - n_q;
      end
      default: wstart = 1'b0;
    endcase
    wpos  = wst_q > V_ZERO;
    znext = wpos ? wz_q + Z_ONE : wz_q - Z_ONE;
    zout  = (znext < Z_ZERO) || (znext >= zs_s);
    wst_n = wpos ? wst_q - V_ONE : wst_q + V_ONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wbusy_q <= 1'b0;
      wph_q   <= 1'b0;
    end else if (wstart) begin
      wbusy_q <= wsteps != '0;
      wph_q   <= 1'b0;
    end else if (wbusy_q) begin
      if (!wph_q) begin
        if (zout) wbusy_q <= 1'b0;
        else      wph_q   <= 1'b1;
      end else begin
        wph_q <= 1'b0;
        if (!rd_blank && (wst_n == '0)) wbusy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wstart) begin
      wz_q  <= worg;
      wst_q <= wsteps;
    end else if (wbusy_q) begin
      if (!wph_q) begin
        wz_q <= znext;
      end else if (!rd_blank) begin
        wst_q <= wst_n;
      end
    end
  end

  assign ram_we    = (op_i == OP_CLR) ||
                     ((op_i == OP_BLANK_WR) && (32'(sec_q) < MAX_SECTIONS));
  assign ram_waddr = (op_i == OP_CLR) ? clr_q : AW'(sec_q);

  pwp_ram #(.WIDTH(1), .DEPTH(MAX_SECTIONS)) u_blank (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ((op_i == OP_CLR) ? 1'b0 : blank_q),
    .raddr_i (znext[AW-1:0]),
    .rdata_o (rd_blank)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      i_q         <= 7'd1;
      out_valid_q <= 1'b0;
    end else begin
      if (op_i == OP_CLR) clr_q <= clr_q + AW'(1);
      if (op_i == OP_I_INIT) i_q <= 7'd1;
      else if (op_i == OP_EMIT) i_q <= i_q + 7'd1;
      if (op_i == OP_EMIT) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign s_ext = 32'(s_q);
  assign e_ext = 32'(e_q);

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_CAPTURE: begin
        wr_q    <= !in_user_i;
        sec_q   <= in_data_i[11:0];
        blank_q <= in_data_i[12];
        ct_q    <= ct_new;
        wb_q    <= wb_new;
        wa_q    <= wa_new;
        cz_q    <= cz_new;
      end
      OP_SET_CS_QUOT: cs_q <= q_v;
      OP_SET_CS_FILL: cs_q <= nfill;
      OP_SET_BASE: begin
        nbase_q  <= q_v;
        nextra_q <= VW'(rem);
      end
      OP_SHARE_CS: n_q <= cs_q;
      OP_SHARE_I:  n_q <= share_i;
      OP_SPLIT: begin
        if (wb_q > wa_q) begin
          nb_q <= q_v;
          na_q <= n_q - q_v - V_ONE;
        end else begin
          na_q <= q_v;
          nb_q <= n_q - q_v - V_ONE;
        end
      end
      OP_TAKE_S: s_q <= (wz_q < Z_ZERO) ? Z_ZERO : wz_q;
      OP_TAKE_E: e_q <= (wz_q >= zs_s) ? zs_m1 : wz_q;
      OP_NLEFT:  nleft_q <= nfill - ext_sum;
      OP_EMIT: begin
        out_data_q <= {7'd0, e_ext[12:0], s_ext[12:0], i_q};
        out_user_q <= s_q > e_q;
        out_last_q <= i_q == nt;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    stat_o.is_write  = wr_q;
    stat_o.mode      = cfg_i.balance_mode;
    stat_o.div_busy  = div_busy;
    stat_o.walk_busy = wbusy_q;
    stat_o.wz_neg    = wz_q < Z_ZERO;
    stat_o.wz_hi     = wz_q >= zs_s;
    stat_o.left_need = left_dvs != 7'd0;
    stat_o.can_emit  = !out_valid_q || out_ready_i;
    stat_o.i_last    = i_q == nt;
    stat_o.clr_last  = 32'(clr_q) == MAX_SECTIONS - 1;
  end

endmodule
